FILE: hdl/udpcs_pkg.sv
// udpcs_pkg: constants and types shared by the UDP checksum stream block.
// No dependencies.
package udpcs_pkg;

    // Width of the packet byte position counter (saturating)
    localparam int OFFSET_BITS = 16;

    // Ones'-complement sum kept in 17 bits (at most 0x10003 between bytes)
    localparam int SUM_BITS = 17;
    // Raw sum of running sum, pseudo word and doubled UDP word
    localparam int RAW_BITS = 19;

    // Packet byte positions of the pseudo-header fields
    localparam int PROTO_OFFSET = 9;
    localparam int ADDR_FIRST   = 12;
    localparam int ADDR_LAST    = 19;

    // Positions within the UDP segment
    localparam int UDP_LEN_LO_REL  = 5;
    localparam int UDP_CSUM_HI_REL = 6;
    localparam int UDP_CSUM_LO_REL = 7;

    // Saturation point of the offset counter
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    // Decoded contribution of one byte to the sum
    typedef struct packed {
        logic [15:0] pseudo_word;
        logic [15:0] udp_word;
        logic        udp_double;
        logic        last;
    } byte_terms_t;

endpackage

FILE: hdl/udp_checksum_stream.sv
// udp_checksum_stream: UDP checksum with IPv4 pseudo header over a byte stream.
// Depends on udpcs_pkg (constants, byte_terms_t).
//
//   channel | ports                                       | carries
//   s_      | s_valid s_ready s_packet_byte s_last_byte   | packet bytes from IP header on
//   m_      | m_valid m_ready m_checksum                  | one checksum per packet
//
// One byte is taken per cycle unless the input stalls. A byte is decoded into sum
// terms in the decode register, then added into the running sum register, and on
// the last byte the checksum lands in the output register, where m_valid is raised.
// Reset (aresetn low, synchronous) clears counters, sum and valids.
// Only a last byte in the decode register waiting behind an untaken checksum
// stalls the input; other bytes keep flowing while the checksum waits.
module udp_checksum_stream (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_packet_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_checksum
);

    localparam int OB = udpcs_pkg::OFFSET_BITS;

    // Input-side packet state
    logic [OB-1:0]  offset_reg, offset_next;
    logic [5:0]     hdr_bytes_reg, hdr_bytes_next;
    logic [7:0]     pending_reg, pending_next;

    // Decode register
    logic                    dec_valid_reg;
    udpcs_pkg::byte_terms_t  dec_reg, dec_next;

    // Sum register and output register
    logic [udpcs_pkg::SUM_BITS-1:0] sum_reg, sum_next;
    logic [15:0]                    csum_reg, csum_next;
    logic                           out_valid_reg;

    logic s_xfer;
    logic advance;

    logic [OB-1:0]  rel;
    logic           in_udp;
    logic [5:0]     hdr_cur;

    logic [udpcs_pkg::RAW_BITS-1:0] raw_sum;
    logic [udpcs_pkg::SUM_BITS-1:0] fold_sum;
    logic [15:0]                    fold_out;

    // Decode stage may move on unless it holds a last byte behind a stalled output
    assign advance = !dec_valid_reg || !dec_reg.last || !out_valid_reg || m_ready;
    assign s_ready = advance;
    assign s_xfer  = s_valid && s_ready;

    // Byte decode: pseudo-header word, UDP word, offset and header length
    always_comb begin
        hdr_cur = (offset_reg == '0) ? {s_packet_byte[3:0], 2'b00} : hdr_bytes_reg;
        in_udp  = offset_reg >= OB'(hdr_cur);
        rel     = offset_reg - OB'(hdr_cur);

        dec_next             = '0;
        dec_next.last        = s_last_byte;
        pending_next         = pending_reg;

        if (offset_reg == OB'(udpcs_pkg::PROTO_OFFSET)) begin
            dec_next.pseudo_word = {8'h00, s_packet_byte};
        end else if (offset_reg >= OB'(udpcs_pkg::ADDR_FIRST) &&
                     offset_reg <= OB'(udpcs_pkg::ADDR_LAST)) begin
            dec_next.pseudo_word = offset_reg[0] ? {8'h00, s_packet_byte}
                                                 : {s_packet_byte, 8'h00};
        end

        if (in_udp) begin
            if (!rel[0]) begin
                pending_next = s_packet_byte;
                if (s_last_byte && rel != OB'(udpcs_pkg::UDP_CSUM_HI_REL)) begin
                    dec_next.udp_word = {s_packet_byte, 8'h00};
                end
            end else if (rel == OB'(udpcs_pkg::UDP_LEN_LO_REL)) begin
                // length word also stands for the pseudo-header length
                dec_next.udp_word   = {pending_reg, s_packet_byte};
                dec_next.udp_double = 1'b1;
            end else if (rel != OB'(udpcs_pkg::UDP_CSUM_LO_REL)) begin
                dec_next.udp_word = {pending_reg, s_packet_byte};
            end
        end

        hdr_bytes_next = hdr_cur;
        offset_next    = (offset_reg != udpcs_pkg::OFFSET_MAX) ? offset_reg + OB'(1)
                                                               : offset_reg;
        if (s_last_byte) begin
            hdr_bytes_next = '0;
            offset_next    = '0;
            pending_next   = '0;
        end
    end

    // Sum update: one three-operand add, one end-around fold
    always_comb begin
        raw_sum = udpcs_pkg::RAW_BITS'(sum_reg)
                + udpcs_pkg::RAW_BITS'(dec_reg.pseudo_word)
                + (dec_reg.udp_double ? udpcs_pkg::RAW_BITS'({dec_reg.udp_word, 1'b0})
                                      : udpcs_pkg::RAW_BITS'(dec_reg.udp_word));
        fold_sum = udpcs_pkg::SUM_BITS'(raw_sum[15:0])
                 + udpcs_pkg::SUM_BITS'(raw_sum[udpcs_pkg::RAW_BITS-1:16]);
        sum_next = dec_reg.last ? '0 : fold_sum;

        // final fold fits 16 bits since fold_sum never exceeds 0x10003
        fold_out  = fold_sum[15:0] + 16'(fold_sum[16]);
        csum_next = (fold_out == 16'hFFFF) ? 16'hFFFF : ~fold_out;
    end

    // Input state and decode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg    <= '0;
            hdr_bytes_reg <= '0;
            pending_reg   <= '0;
            dec_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                offset_reg    <= offset_next;
                hdr_bytes_reg <= hdr_bytes_next;
                pending_reg   <= pending_next;
            end
            if (advance) begin
                dec_valid_reg <= s_xfer;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s_xfer) begin
            dec_reg <= dec_next;
        end
    end

    // Running sum and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (dec_valid_reg && advance) begin
                sum_reg <= sum_next;
                if (dec_reg.last) begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dec_valid_reg && advance && dec_reg.last) begin
            csum_reg <= csum_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_checksum = csum_reg;

    // Input stalls only for a last byte behind an untaken checksum
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> dec_valid_reg && dec_reg.last && out_valid_reg)
        else $error("input stalled without a pending last byte");

    // Sum stays within its folded bound
    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg <= udpcs_pkg::SUM_BITS'(17'h10003))
        else $error("running sum out of folded range");

    // A last byte clears the packet state
    a_last_clears_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && s_last_byte |=> offset_reg == '0 && hdr_bytes_reg == '0)
        else $error("packet state not cleared after last byte");

    a_last_clears_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        dec_valid_reg && advance && dec_reg.last |=> sum_reg == '0 && m_valid)
        else $error("sum not cleared or checksum missing after last byte");

    // A zero checksum is always sent as all ones
    a_no_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_checksum != 16'h0000)
        else $error("zero checksum sent");

endmodule

FILE: test/udp_checksum_stream_tb.sv
// udp_checksum_stream_tb: self-checking bench for the streaming UDP checksum block.
// Depends on udpcs_pkg (offset width, pseudo-header and UDP field positions)
// and udp_checksum_stream.
module udp_checksum_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_BYTES    = 275;
    localparam int PHASE_PACKETS  = 6;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } pkt_byte_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_packet_byte = 8'h00;
    logic        s_last_byte   = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [15:0] m_checksum;

    // Stimulus and scoreboard storage
    pkt_byte_t   pending_q[$];
    logic [7:0]  build_q[$];
    logic [15:0] expected_checksums[$];
    int unsigned queued_bytes = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned errors = 0;
    int unsigned stall_cycles = 0;

    // Checksum tracker state, mirrors the block's per-packet state
    logic [udpcs_pkg::OFFSET_BITS-1:0] byte_pos    = '0;
    logic [5:0]                        hdr_len     = '0;
    logic [31:0]                       csum_acc    = '0;
    logic [7:0]                        udp_hi_byte = '0;

    udp_checksum_stream DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_packet_byte (s_packet_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_checksum    (m_checksum)
    );

    always #2 aclk = ~aclk;

    // Ones'-complement add with a single end-around carry
    function automatic logic [31:0] ones_add(input logic [31:0] s, input logic [15:0] w);
        logic [31:0] t;
        t = s + {16'h0000, w};
        return {16'h0000, t[15:0]} + {16'h0000, t[31:16]};
    endfunction

    // Fold one accepted byte into the checksum; queue the checksum on the last byte
    task automatic sum_packet_byte(input logic [7:0] b, input logic last);
        logic [udpcs_pkg::OFFSET_BITS-1:0] off;
        logic [udpcs_pkg::OFFSET_BITS-1:0] rel;
        logic [15:0]                       w;
        logic [31:0]                       s;
        logic [15:0]                       c;
        off = byte_pos;
        if (off == 0) hdr_len = {b[3:0], 2'b00};

        // pseudo header: protocol, source and destination addresses
        if (off == udpcs_pkg::PROTO_OFFSET)
            csum_acc = ones_add(csum_acc, {8'h00, b});
        else if (off >= udpcs_pkg::ADDR_FIRST && off <= udpcs_pkg::ADDR_LAST)
            csum_acc = ones_add(csum_acc, off[0] ? {8'h00, b} : {b, 8'h00});

        // UDP segment, big-endian words, checksum field skipped
        if (off >= hdr_len) begin
            rel = off - hdr_len;
            if (!rel[0]) begin
                udp_hi_byte = b;
                if (last && rel != udpcs_pkg::UDP_CSUM_HI_REL)
                    csum_acc = ones_add(csum_acc, {b, 8'h00});
            end else begin
                w = {udp_hi_byte, b};
                if (rel == udpcs_pkg::UDP_LEN_LO_REL) begin
                    // length counts once more for the pseudo header
                    csum_acc = ones_add(csum_acc, w);
                    csum_acc = ones_add(csum_acc, w);
                end else if (rel != udpcs_pkg::UDP_CSUM_LO_REL) begin
                    csum_acc = ones_add(csum_acc, w);
                end
            end
        end

        if (off != udpcs_pkg::OFFSET_MAX) byte_pos = off + 1'b1;

        if (last) begin
            s = csum_acc;
            while (s > 32'h0000FFFF) s = {16'h0000, s[15:0]} + {16'h0000, s[31:16]};
            c = ~s[15:0];
            if (c == 16'h0000) c = 16'hFFFF;
            expected_checksums.push_back(c);
            byte_pos    = '0;
            hdr_len     = '0;
            csum_acc    = '0;
            udp_hi_byte = '0;
        end
    endtask

    // Move the packet under construction to the send queue, last flag on its final byte
    task automatic commit_packet();
        pkt_byte_t item;
        foreach (build_q[i]) begin
            item.data = build_q[i];
            item.last = (i == build_q.size() - 1);
            pending_q.push_back(item);
        end
        queued_bytes += build_q.size();
        build_q.delete();
    endtask

    // Mostly well-formed packets with random content; some short headers and cut-off packets
    task automatic queue_random_packet();
        int unsigned kind;
        int unsigned ihl;
        int unsigned hdr;
        int unsigned udp_len;
        int unsigned total;
        kind = $urandom_range(0, 99);
        if (kind < 60)      ihl = 5;
        else if (kind < 75) ihl = $urandom_range(6, 15);
        else if (kind < 88) ihl = $urandom_range(0, 4);
        else                ihl = $urandom_range(0, 15);
        hdr = 4 * ihl;
        udp_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 24);
        total = hdr + udp_len;
        // cut-off packet: last flag may land inside the IP header
        if (kind >= 88) total = $urandom_range(1, hdr + 8);

        build_q.push_back({4'($urandom_range(0, 15)), 4'(ihl)});
        for (int i = 1; i < total; i++) build_q.push_back(8'($urandom_range(0, 255)));
        if (kind < 88 && hdr + 5 < total) begin
            build_q[hdr + 4] = udp_len[15:8];
            build_q[hdr + 5] = udp_len[7:0];
        end
        commit_packet();
    endtask

    // Hold the sender until the queue is empty and every checksum is back
    task automatic wait_drained();
        while (pending_q.size() != 0 || s_valid || expected_checksums.size() != 0)
            @(negedge aclk);
    endtask

    // Sender: next byte when the slot is free, with random idle cycles
    always @(posedge aclk) begin : drive
        pkt_byte_t item;
        if (!aresetn) begin
            s_valid       <= 1'b0;
            s_packet_byte <= 8'h00;
            s_last_byte   <= 1'b0;
            m_ready       <= 1'b0;
        end else begin
            if (!s_valid || s_ready) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    item = pending_q.pop_front();
                    s_valid       <= 1'b1;
                    s_packet_byte <= item.data;
                    s_last_byte   <= item.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: check checksum transfers, then track accepted bytes
    always @(posedge aclk) begin : observe
        logic [15:0] want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_checksums.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected checksum, expected none, got %h", $time,
                             m_checksum);
                end else begin
                    want = expected_checksums.pop_front();
                    if (m_checksum !== want) begin
                        errors++;
                        $display("%0t: checksum mismatch, expected %h, got %h", $time,
                                 want, m_checksum);
                    end
                end
            end
            if (s_valid && s_ready) sum_packet_byte(s_packet_byte, s_last_byte);
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("udp_checksum_stream test failed");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned n_packets;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: IHL 0 with odd length and an all-ones sum (zero sent as 0xFFFF)
        build_q = '{8'hF0, 8'hFF, 8'h0F};
        commit_packet();
        // short header: UDP region starts at 8 and overlaps the addresses
        build_q = '{8'h42, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h40, 8'h00,
                    8'hA5, 8'h5A, 8'h00, 8'h08, 8'hC0, 8'hA8, 8'hFE, 8'hED};
        commit_packet();
        // last byte before the UDP region, all-ones bytes
        build_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        commit_packet();
        // single zero byte
        build_q = '{8'h00};
        commit_packet();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            queued_bytes = 0;
            n_packets = 0;
            while (queued_bytes < PHASE_BYTES || n_packets < PHASE_PACKETS) begin
                queue_random_packet();
                n_packets++;
            end
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (errors == 0 && expected_checksums.size() == 0)
            $display("udp_checksum_stream test passed");
        else
            $display("udp_checksum_stream test failed");
        $finish;
    end

endmodule
